>>> hw/rtl/ptok_pkg.sv
// ----------------------------------------------------------------------------
// ptok_pkg
// shared types, codes and keyword tables for the pascal tokenizer
// ----------------------------------------------------------------------------
`default_nettype none

package ptok_pkg;

	typedef enum logic [3:0] {
		MODE_IDLE      = 4'd0,
		MODE_NAME      = 4'd1,
		MODE_NUMBER    = 4'd2,
		MODE_NUM_DOT   = 4'd3,
		MODE_STRING    = 4'd4,
		MODE_STR_QUOTE = 4'd5,
		MODE_ESCAPE    = 4'd6,
		MODE_BRACE     = 4'd7,
		MODE_LINE      = 4'd8,
		MODE_PEND      = 4'd9
	} mode_t;

	localparam logic [4:0] KIND_KEYWORD   = 5'd0;
	localparam logic [4:0] KIND_NAME      = 5'd1;
	localparam logic [4:0] KIND_NUMBER    = 5'd2;
	localparam logic [4:0] KIND_STRING    = 5'd3;
	localparam logic [4:0] KIND_CHAR      = 5'd4;
	localparam logic [4:0] KIND_ESCAPED   = 5'd5;
	localparam logic [4:0] KIND_MAC_START = 5'd6;
	localparam logic [4:0] KIND_MAC_KW    = 5'd7;
	localparam logic [4:0] KIND_MAC_END   = 5'd8;
	localparam logic [4:0] KIND_MINUS     = 5'd10;
	localparam logic [4:0] KIND_SLASH     = 5'd12;
	localparam logic [4:0] KIND_DOT       = 5'd23;
	localparam logic [4:0] KIND_END       = 5'd27;

	localparam int KW_COUNT  = 39;
	localparam int DIR_COUNT = 3;
	localparam int KW_CHARS  = 14;

	typedef logic [KW_CHARS*8-1:0] kw_str_t;

	// keywords, left aligned, zero padded
	function automatic kw_str_t kw_entry(input logic [5:0] idx);
		kw_str_t s;
		s = '0;
		case (idx)
			6'd0:  s = {"program",        56'd0};
			6'd1:  s = {"unit",           80'd0};
			6'd2:  s = {"uses",           80'd0};
			6'd3:  s = {"begin",          72'd0};
			6'd4:  s = {"end",            88'd0};
			6'd5:  s = {"procedure",      40'd0};
			6'd6:  s = {"function",       48'd0};
			6'd7:  s = {"var",            88'd0};
			6'd8:  s = {"if",             96'd0};
			6'd9:  s = {"then",           80'd0};
			6'd10: s = {"else",           80'd0};
			6'd11: s = {"while",          72'd0};
			6'd12: s = {"do",             96'd0};
			6'd13: s = {"for",            88'd0};
			6'd14: s = {"to",             96'd0};
			6'd15: s = {"break",          72'd0};
			6'd16: s = {"repeat",         64'd0};
			6'd17: s = {"until",          72'd0};
			6'd18: s = {"type",           80'd0};
			6'd19: s = {"array",          72'd0};
			6'd20: s = {"of",             96'd0};
			6'd21: s = {"const",          72'd0};
			6'd22: s = {"true",           80'd0};
			6'd23: s = {"false",          72'd0};
			6'd24: s = {"and",            88'd0};
			6'd25: s = {"or",             96'd0};
			6'd26: s = {"not",            88'd0};
			6'd27: s = {"record",         64'd0};
			6'd28: s = {"external",       48'd0};
			6'd29: s = {"name",           80'd0};
			6'd30: s = {"mod",            88'd0};
			6'd31: s = {"inline",         64'd0};
			6'd32: s = "implementation";
			6'd33: s = {"interface",      40'd0};
			6'd34: s = {"finalization",   16'd0};
			6'd35: s = "initialization";
			6'd36: s = {"div",            88'd0};
			6'd37: s = {"downto",         64'd0};
			6'd38: s = {"file",           80'd0};
			default: s = '0;
		endcase
		return s;
	endfunction

	function automatic kw_str_t dir_entry(input logic [1:0] idx);
		kw_str_t s;
		s = '0;
		case (idx)
			2'd0: s = {"ifdef", 72'd0};
			2'd1: s = {"else",  80'd0};
			2'd2: s = {"endif", 72'd0};
			default: s = '0;
		endcase
		return s;
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == "_";
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic [4:0] punct_kind(input logic [7:0] b);
		logic [4:0] k;
		case (b)
			"+": k = 5'd9;
			"-": k = 5'd10;
			"*": k = 5'd11;
			"/": k = 5'd12;
			"(": k = 5'd13;
			")": k = 5'd14;
			"[": k = 5'd15;
			"]": k = 5'd16;
			"=": k = 5'd17;
			"<": k = 5'd18;
			">": k = 5'd19;
			",": k = 5'd20;
			";": k = 5'd21;
			":": k = 5'd22;
			".": k = 5'd23;
			"^": k = 5'd24;
			"!": k = 5'd25;
			"@": k = 5'd26;
			default: k = 5'd0;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pascal_tokenizer.sv
// ----------------------------------------------------------------------------
// pascal_tokenizer
// streaming pascal tokenizer, while not stalled one source byte per cycle
// ----------------------------------------------------------------------------
// usage:
//   the input channel (in_valid/in_stall) carries one source byte with its
//   final_byte flag per transaction. each byte may close up to three tokens;
//   they leave on the output channel (out_valid/out_stall) one per
//   transaction, run_last marking the last token caused by a byte.
//   throughput: one byte per cycle while each byte causes at most one token
//   and out_stall is low; a byte that causes more tokens holds the input
//   while the single output port drains its earlier ones from the result slots.
//   latency: the first token of a byte is valid the cycle after the byte is
//   taken (one register stage between scanner and port).
//   a byte that causes no token leaves nothing on the output.
//   reset clears the scan state but for the name buffer, counters return to offset 0, row 1, col 1.
//   while out_stall is high the current token holds; the input is stalled
//   while tokens other than the current one are left to deliver, or while
//   the last token of a byte is itself stalled.
//   the final byte flushes the open token, adds an end token and returns
//   the scanner to its reset state for the next text.
// ----------------------------------------------------------------------------
`default_nettype none

module pascal_tokenizer import ptok_pkg::*; #(
	parameter int NAME_CHARS  = 16,
	parameter int OFFSET_BITS = 24,
	parameter int LINE_BITS   = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] byte_value,
	input  wire logic       final_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [4:0]      token_kind,
	output logic [5:0]      keyword_index,
	output logic [23:0]     start_offset,
	output logic [23:0]     token_length,
	output logic [15:0]     line_number,
	output logic [15:0]     column_number,
	output logic            run_last
);

	localparam int LEN_BITS = $clog2(NAME_CHARS + 2);
	localparam int OB = OFFSET_BITS;
	localparam int LB = LINE_BITS;
	localparam logic [OB-1:0] POS_TOP = '1;
	localparam logic [LB-1:0] ROW_TOP = '1;

	typedef struct packed {
		logic [4:0]    kind;
		logic [5:0]    idx;
		logic [OB-1:0] start;
		logic [OB-1:0] len;
		logic [LB-1:0] row;
		logic [LB-1:0] col;
	} tok_t;

	// scan state
	mode_t                 mode_q;
	logic                  dir_q;
	logic [7:0]            held_q;
	logic [NAME_CHARS*8-1:0] name_q;
	logic [LEN_BITS-1:0]   nlen_q;
	logic [OB-1:0]         begin_q, pos_q, mark_pos_q;
	logic [LB-1:0]         row_q, col_q, trow_q, tcol_q, mrow_q, mcol_q;

	// result slots
	tok_t       slot_s1 [3];
	logic [1:0] cnt_s1;
	logic [1:0] rd_s1;

	logic accept;
	logic last_out;
	assign last_out = (rd_s1 + 2'd1 == cnt_s1);
	assign in_stall = out_valid && !(last_out && !out_stall);
	assign accept   = in_valid && !in_stall;

	// keyword lookup on current buffer
	logic [4:0] m_kind;
	logic [5:0] m_idx;

	ptok_match #(.NAME_CHARS(NAME_CHARS), .LEN_BITS(LEN_BITS)) u_match (
		.name(name_q), .name_len(nlen_q), .directive(dir_q),
		.kind(m_kind), .index(m_idx)
	);

	function automatic logic [OB-1:0] diff(input logic [OB-1:0] a, input logic [OB-1:0] b);
		return (a > b) ? a - b : '0;
	endfunction

	// combinational scan of one byte
	tok_t       res [3];
	logic [1:0] n;
	mode_t      mode_d;
	logic       dir_d;
	logic [7:0] held_d;
	logic [NAME_CHARS*8-1:0] name_d;
	logic [LEN_BITS-1:0] nlen_d;
	logic [OB-1:0] begin_d, mark_pos_d, pos_n;
	logic [LB-1:0] trow_d, tcol_d, mrow_d, mcol_d, row_n, col_n;
	logic [OB-1:0] pos_inc;
	logic consumed;
	logic [7:0] b, lc;
	logic [4:0] pk;
	logic [LEN_BITS-1:0] alen;

	always_comb begin
		b = byte_value;
		lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
		pk = punct_kind(b);
		pos_inc = (pos_q < POS_TOP) ? pos_q + 1'b1 : POS_TOP;
		for (int i = 0; i < 3; i++) res[i] = '0;
		n = '0;
		mode_d = mode_q; dir_d = dir_q; held_d = held_q; name_d = name_q;
		nlen_d = nlen_q; begin_d = begin_q; mark_pos_d = mark_pos_q;
		trow_d = trow_q; tcol_d = tcol_q; mrow_d = mrow_q; mcol_d = mcol_q;
		consumed = 1'b0;

		// continue the open token
		case (mode_q)
			MODE_NAME: begin
				if (is_alpha(b) || is_digit(b)) begin
					consumed = 1'b1;
				end else begin
					res[n] = '{m_kind, m_idx, begin_q, diff(pos_q, begin_q), trow_q, tcol_q};
					n = n + 2'd1;
				end
			end
			MODE_NUMBER: begin
				if (is_digit(b)) begin
					consumed = 1'b1;
				end else if (b == ".") begin
					consumed = 1'b1; mark_pos_d = pos_q; mrow_d = row_q; mcol_d = col_q;
					mode_d = MODE_NUM_DOT;
				end else begin
					res[n] = '{KIND_NUMBER, 6'd0, begin_q, diff(pos_q, begin_q), trow_q, tcol_q};
					n = n + 2'd1;
				end
			end
			MODE_NUM_DOT: begin
				if (is_digit(b)) begin
					consumed = 1'b1; mode_d = MODE_NUMBER;
				end else if (final_byte) begin
					res[n] = '{KIND_NUMBER, 6'd0, begin_q,
						diff((mark_pos_q < POS_TOP) ? mark_pos_q + 1'b1 : POS_TOP, begin_q),
						trow_q, tcol_q};
					n = n + 2'd1;
				end else begin
					res[n] = '{KIND_NUMBER, 6'd0, begin_q, diff(mark_pos_q, begin_q),
						trow_q, tcol_q};
					res[n+2'd1] = '{KIND_DOT, 6'd0, mark_pos_q, OB'(1), mrow_q, mcol_q};
					n = n + 2'd2;
				end
			end
			MODE_STRING: begin
				consumed = 1'b1;
				if (b == "'") begin
					mark_pos_d = pos_q; mode_d = MODE_STR_QUOTE;
				end
			end
			MODE_STR_QUOTE: begin
				if (b == "'") begin
					consumed = 1'b1; mode_d = MODE_STRING;
				end else begin
					res[n] = '{(diff(mark_pos_q, begin_q) == OB'(1)) ? KIND_CHAR : KIND_STRING,
						6'd0, begin_q, diff(mark_pos_q, begin_q), trow_q, tcol_q};
					n = n + 2'd1;
				end
			end
			MODE_ESCAPE: begin
				if (b == "#" || is_digit(b)) begin
					consumed = 1'b1;
				end else begin
					res[n] = '{(diff(pos_q, begin_q) == OB'(1)) ? KIND_CHAR : KIND_ESCAPED,
						6'd0, begin_q, diff(pos_q, begin_q), trow_q, tcol_q};
					n = n + 2'd1;
				end
			end
			MODE_BRACE: begin
				consumed = 1'b1;
				if (b == "}") mode_d = MODE_IDLE;
			end
			MODE_LINE: begin
				consumed = 1'b1;
				if (b == 8'h0a) mode_d = MODE_IDLE;
			end
			MODE_PEND: begin
				if (held_q == "-") begin
					if (is_digit(b)) begin
						consumed = 1'b1; mode_d = MODE_NUMBER;
					end else begin
						res[n] = '{KIND_MINUS, 6'd0, begin_q, OB'(1), trow_q, tcol_q};
						n = n + 2'd1;
					end
				end else if (held_q == "/") begin
					if (b == "/") begin
						consumed = 1'b1; mode_d = MODE_LINE;
					end else begin
						res[n] = '{KIND_SLASH, 6'd0, begin_q, OB'(1), trow_q, tcol_q};
						n = n + 2'd1;
					end
				end else begin
					consumed = 1'b1;
					if (b == "$") begin
						res[n] = '{KIND_MAC_START, 6'd0, begin_q, OB'(2), trow_q, tcol_q};
						n = n + 2'd1;
						dir_d = 1'b1; mode_d = MODE_IDLE;
					end else begin
						mode_d = (b == "}") ? MODE_IDLE : MODE_BRACE;
					end
				end
			end
			default: ;
		endcase

		if (consumed) begin
			// name continuation writes the buffer
			if (mode_q == MODE_NAME) begin
				for (int j = 0; j < NAME_CHARS; j++)
					if (LEN_BITS'(j) == nlen_q) name_d[j*8 +: 8] = lc;
				if (nlen_q <= LEN_BITS'(NAME_CHARS)) nlen_d = nlen_q + 1'b1;
			end
		end else begin
			// start a fresh token
			begin_d = pos_q; trow_d = row_q; tcol_d = col_q;
			mode_d = MODE_IDLE;
			if (is_alpha(b)) begin
				name_d[7:0] = lc; nlen_d = LEN_BITS'(1); mode_d = MODE_NAME;
			end else if (is_digit(b)) begin
				mode_d = MODE_NUMBER;
			end else if (b == "-" || b == "/" || b == "{") begin
				held_d = b; mode_d = MODE_PEND;
			end else if (b == "'") begin
				begin_d = pos_inc; mode_d = MODE_STRING;
			end else if (b == "#") begin
				mode_d = MODE_ESCAPE;
			end else if (b == "}") begin
				res[n] = '{KIND_MAC_END, 6'd0, pos_q, OB'(1), row_q, col_q};
				n = n + 2'd1;
				dir_d = 1'b0;
			end else if (pk != 5'd0) begin
				res[n] = '{pk, 6'd0, pos_q, OB'(1), row_q, col_q};
				n = n + 2'd1;
			end
		end
		alen = nlen_d;

		pos_n = pos_inc;
		if (b == 8'h0a) begin
			row_n = (row_q < ROW_TOP) ? row_q + 1'b1 : ROW_TOP;
			col_n = LB'(1);
		end else begin
			row_n = row_q;
			col_n = (col_q < ROW_TOP) ? col_q + 1'b1 : ROW_TOP;
		end
	end

	// flush and end token on the final byte; only a name still in progress
	// needs a second lookup, done here against the updated buffer
	logic [4:0] f_kind;
	logic [5:0] f_idx;

	ptok_match #(.NAME_CHARS(NAME_CHARS), .LEN_BITS(LEN_BITS)) u_match_fin (
		.name(name_d), .name_len(alen), .directive(dir_d),
		.kind(f_kind), .index(f_idx)
	);

	tok_t       fres [3];
	logic [1:0] fn;

	always_comb begin
		for (int i = 0; i < 3; i++) fres[i] = res[i];
		fn = n;
		if (final_byte) begin
			case (mode_d)
				MODE_NAME: begin
					fres[fn] = '{f_kind, f_idx, begin_d, diff(pos_n, begin_d), trow_d, tcol_d};
					fn = fn + 2'd1;
				end
				MODE_NUMBER: begin
					fres[fn] = '{KIND_NUMBER, 6'd0, begin_d, diff(pos_n, begin_d),
						trow_d, tcol_d};
					fn = fn + 2'd1;
				end
				MODE_NUM_DOT: begin
					fres[fn] = '{KIND_NUMBER, 6'd0, begin_d, diff(mark_pos_d, begin_d),
						trow_d, tcol_d};
					fres[fn+2'd1] = '{KIND_DOT, 6'd0, mark_pos_d, OB'(1), mrow_d, mcol_d};
					fn = fn + 2'd2;
				end
				MODE_STRING: begin
					fres[fn] = '{(diff(pos_n, begin_d) == OB'(1)) ? KIND_CHAR : KIND_STRING,
						6'd0, begin_d, diff(pos_n, begin_d), trow_d, tcol_d};
					fn = fn + 2'd1;
				end
				MODE_STR_QUOTE: begin
					fres[fn] = '{(diff(mark_pos_d, begin_d) == OB'(1)) ? KIND_CHAR
						: KIND_STRING, 6'd0, begin_d, diff(mark_pos_d, begin_d),
						trow_d, tcol_d};
					fn = fn + 2'd1;
				end
				MODE_ESCAPE: begin
					fres[fn] = '{(diff(pos_n, begin_d) == OB'(1)) ? KIND_CHAR : KIND_ESCAPED,
						6'd0, begin_d, diff(pos_n, begin_d), trow_d, tcol_d};
					fn = fn + 2'd1;
				end
				MODE_PEND: begin
					if (held_d == "-") begin
						fres[fn] = '{KIND_MINUS, 6'd0, begin_d, OB'(1), trow_d, tcol_d};
						fn = fn + 2'd1;
					end else if (held_d == "/") begin
						fres[fn] = '{KIND_SLASH, 6'd0, begin_d, OB'(1), trow_d, tcol_d};
						fn = fn + 2'd1;
					end
				end
				default: ;
			endcase
			fres[fn] = '{KIND_END, 6'd0, pos_n, '0, row_n, col_n};
			fn = fn + 2'd1;
		end
	end

	// scan state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE; dir_q <= 1'b0; held_q <= '0; nlen_q <= '0;
			begin_q <= '0; pos_q <= '0; mark_pos_q <= '0;
			row_q <= LB'(1); col_q <= LB'(1); trow_q <= LB'(1); tcol_q <= LB'(1);
			mrow_q <= '0; mcol_q <= '0;
		end else if (accept) begin
			if (final_byte) begin
				mode_q <= MODE_IDLE; dir_q <= 1'b0; held_q <= '0; nlen_q <= '0;
				begin_q <= '0; pos_q <= '0; mark_pos_q <= '0;
				row_q <= LB'(1); col_q <= LB'(1); trow_q <= LB'(1); tcol_q <= LB'(1);
				mrow_q <= '0; mcol_q <= '0;
			end else begin
				mode_q <= mode_d; dir_q <= dir_d; held_q <= held_d; nlen_q <= nlen_d;
				begin_q <= begin_d; pos_q <= pos_n; mark_pos_q <= mark_pos_d;
				row_q <= row_n; col_q <= col_n; trow_q <= trow_d; tcol_q <= tcol_d;
				mrow_q <= mrow_d; mcol_q <= mcol_d;
			end
		end
	end

	// name buffer, no reset
	always_ff @(posedge clk) begin
		if (accept) name_q <= name_d;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1 <= '0; rd_s1 <= '0;
		end else if (accept) begin
			cnt_s1 <= fn; rd_s1 <= '0;
		end else if (out_valid && !out_stall) begin
			if (last_out) begin
				cnt_s1 <= '0; rd_s1 <= '0;
			end else begin
				rd_s1 <= rd_s1 + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) for (int i = 0; i < 3; i++) slot_s1[i] <= fres[i];
	end

	tok_t cur;
	assign cur           = slot_s1[rd_s1];
	assign out_valid     = (cnt_s1 != 2'd0);
	assign token_kind    = cur.kind;
	assign keyword_index = cur.idx;
	assign start_offset  = 24'(cur.start);
	assign token_length  = 24'(cur.len);
	assign line_number   = 16'(cur.row);
	assign column_number = 16'(cur.col);
	assign run_last      = last_out;

endmodule

`default_nettype wire

>>> hw/rtl/ptok_match.sv
// ----------------------------------------------------------------------------
// ptok_match
// keyword and directive lookup over the lower-cased name buffer
// ----------------------------------------------------------------------------
`default_nettype none

module ptok_match import ptok_pkg::*; #(
	parameter int NAME_CHARS = 16,
	parameter int LEN_BITS   = 7
) (
	input  wire logic [NAME_CHARS*8-1:0] name,
	input  wire logic [LEN_BITS-1:0]     name_len,
	input  wire logic                    directive,
	output logic [4:0]                   kind,
	output logic [5:0]                   index
);

	localparam int CMP_CHARS = (NAME_CHARS < KW_CHARS) ? NAME_CHARS : KW_CHARS;

	// compare one table string against the buffer, bytes past len must be zero
	function automatic logic str_hit(input kw_str_t s, input logic [NAME_CHARS*8-1:0] nm,
	                                 input logic [LEN_BITS-1:0] len);
		logic hit;
		logic [7:0] c;
		hit = (len <= LEN_BITS'(KW_CHARS)) && (len != '0);
		for (int j = 0; j < KW_CHARS; j++) begin
			c = s[(KW_CHARS-1-j)*8 +: 8];
			if (LEN_BITS'(j) < len) begin
				if (j >= CMP_CHARS || c != nm[j*8 +: 8]) hit = 1'b0;
			end else if (c != 8'd0) begin
				hit = 1'b0;
			end
		end
		return hit;
	endfunction

	logic       kw_hit, dir_hit;
	logic [5:0] kw_idx;
	logic [1:0] dir_idx;

	always_comb begin
		kw_hit = 1'b0;
		kw_idx = '0;
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			if (str_hit(kw_entry(6'(i)), name, name_len)) begin
				kw_hit = 1'b1;
				kw_idx = 6'(i);
			end
		end
		dir_hit = 1'b0;
		dir_idx = '0;
		for (int i = DIR_COUNT - 1; i >= 0; i--) begin
			if (str_hit(dir_entry(2'(i)), name, name_len)) begin
				dir_hit = 1'b1;
				dir_idx = 2'(i);
			end
		end
	end

	always_comb begin
		if (directive && dir_hit) begin
			kind  = KIND_MAC_KW;
			index = {4'd0, dir_idx};
		end else if (kw_hit) begin
			kind  = KIND_KEYWORD;
			index = kw_idx;
		end else begin
			kind  = KIND_NAME;
			index = '0;
		end
	end

endmodule

`default_nettype wire
